FILE: sv/i2cts_pkg.sv
// Shared types, codes and helpers for the I2C target line sampler.
package i2cts_pkg;

	localparam int BYTE_BITS = 8;

	typedef enum logic [1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_LOAD_TX  = 2'd1,
		CMD_CLR_PEND = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	localparam logic [2:0] PH_CODE_LISTEN      = 3'd0;
	localparam logic [2:0] PH_CODE_START       = 3'd1;
	localparam logic [2:0] PH_CODE_ADDRESS     = 3'd2;
	localparam logic [2:0] PH_CODE_ACK_ADDR    = 3'd3;
	localparam logic [2:0] PH_CODE_PAYLOAD     = 3'd4;
	localparam logic [2:0] PH_CODE_RESPOND     = 3'd5;
	localparam logic [2:0] PH_CODE_READ_ACK    = 3'd6;
	localparam logic [2:0] PH_CODE_ACK_PAYLOAD = 3'd7;

	typedef enum logic [7:0] {
		PH_LISTEN      = 8'b0000_0001,
		PH_START       = 8'b0000_0010,
		PH_ADDRESS     = 8'b0000_0100,
		PH_ACK_ADDR    = 8'b0000_1000,
		PH_PAYLOAD     = 8'b0001_0000,
		PH_RESPOND     = 8'b0010_0000,
		PH_READ_ACK    = 8'b0100_0000,
		PH_ACK_PAYLOAD = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic       scl;
		logic       sda;
		logic [7:0] tx_byte;
	} item_t;

	typedef struct packed {
		logic       sda_pull;
		logic [7:0] rx_byte;
		logic       rx_pending;
		logic [2:0] bus_phase;
		logic       read_direction;
	} res_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_LISTEN:      code = PH_CODE_LISTEN;
			PH_START:       code = PH_CODE_START;
			PH_ADDRESS:     code = PH_CODE_ADDRESS;
			PH_ACK_ADDR:    code = PH_CODE_ACK_ADDR;
			PH_PAYLOAD:     code = PH_CODE_PAYLOAD;
			PH_RESPOND:     code = PH_CODE_RESPOND;
			PH_READ_ACK:    code = PH_CODE_READ_ACK;
			PH_ACK_PAYLOAD: code = PH_CODE_ACK_PAYLOAD;
			default:        code = PH_CODE_LISTEN;
		endcase
		return code;
	endfunction

endpackage

FILE: sv/i2cts_core.sv
// Bus state machine: line edge detection, address match, receive and transmit shifting.
module i2cts_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  i2cts_pkg::item_t   item,
	input  logic [6:0]         own_address,
	output i2cts_pkg::res_t    res
);
	import i2cts_pkg::*;

	phase_t      phase_q, phase_n;
	logic        last_scl_q, last_scl_n;
	logic        last_sda_q, last_sda_n;
	logic [3:0]  rx_cnt_q, rx_cnt_n;
	logic [7:0]  rx_shift_q, rx_shift_n;
	logic [7:0]  held_q, held_n;
	logic        pending_q, pending_n;
	logic        read_mode_q, read_mode_n;
	logic [7:0]  answer_q, answer_n;
	logic [3:0]  tx_cnt_q, tx_cnt_n;
	logic        drive_q, drive_n;
	logic        byte_done;

	always_comb begin
		phase_n     = phase_q;
		last_scl_n  = last_scl_q;
		last_sda_n  = last_sda_q;
		rx_cnt_n    = rx_cnt_q;
		rx_shift_n  = rx_shift_q;
		held_n      = held_q;
		pending_n   = pending_q;
		read_mode_n = read_mode_q;
		answer_n    = answer_q;
		tx_cnt_n    = tx_cnt_q;
		drive_n     = drive_q;
		byte_done   = 1'b0;

		unique case (cmd_t'(item.command))
			CMD_SAMPLE: begin
				if (last_scl_q && !item.scl) begin
					// one bus bit per falling SCL edge
					if (phase_q == PH_ADDRESS || phase_q == PH_PAYLOAD) begin
						if (!rx_cnt_q[3])
							rx_shift_n[~rx_cnt_q[2:0]] = item.sda;
						rx_cnt_n  = rx_cnt_q + 4'd1;
						byte_done = (rx_cnt_n == 4'(BYTE_BITS));
					end
					if (phase_q == PH_RESPOND ||
							(phase_q == PH_ACK_ADDR && read_mode_q)) begin
						if (!tx_cnt_q[3])
							drive_n = ~answer_q[~tx_cnt_q[2:0]];
						else
							drive_n = 1'b0;
						tx_cnt_n = tx_cnt_q + 4'd1;
					end
					unique case (phase_q)
						PH_START: phase_n = PH_ADDRESS;
						PH_ADDRESS: begin
							if (byte_done) begin
								held_n   = rx_shift_n;
								rx_cnt_n = '0;
								if (rx_shift_n[7:1] == own_address) begin
									read_mode_n = rx_shift_n[0];
									drive_n     = 1'b1;
									phase_n     = PH_ACK_ADDR;
								end else begin
									phase_n = PH_LISTEN;
								end
							end
						end
						PH_ACK_ADDR: begin
							if (!read_mode_q) begin
								drive_n = 1'b0;
								phase_n = PH_PAYLOAD;
							end else begin
								phase_n = PH_RESPOND;
							end
						end
						PH_PAYLOAD: begin
							if (byte_done) begin
								held_n    = rx_shift_n;
								pending_n = 1'b1;
								drive_n   = 1'b1;
								phase_n   = PH_ACK_PAYLOAD;
							end
						end
						PH_RESPOND: begin
							// ninth edge: byte sent, let go of SDA for the master's ack
							if (tx_cnt_n >= 4'(BYTE_BITS + 1)) begin
								tx_cnt_n = '0;
								drive_n  = 1'b0;
								phase_n  = PH_READ_ACK;
							end
						end
						PH_READ_ACK: phase_n = PH_PAYLOAD;
						PH_ACK_PAYLOAD: begin
							drive_n  = 1'b0;
							rx_cnt_n = '0;
							phase_n  = PH_PAYLOAD;
						end
						default: phase_n = phase_n;
					endcase
				end
				if (item.scl) begin
					if (last_sda_q && !item.sda &&
							(phase_n == PH_LISTEN || phase_n == PH_PAYLOAD)) begin
						rx_cnt_n    = '0;
						tx_cnt_n    = '0;
						read_mode_n = 1'b0;
						phase_n     = PH_START;
					end
					if (!last_sda_q && item.sda) begin
						phase_n  = PH_LISTEN;
						rx_cnt_n = '0;
					end
				end
				last_scl_n = item.scl;
				last_sda_n = item.sda;
			end
			CMD_LOAD_TX:  answer_n  = item.tx_byte;
			CMD_CLR_PEND: pending_n = 1'b0;
			CMD_NOP:      ;
			default:      ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LISTEN;
			last_scl_q  <= 1'b1;
			last_sda_q  <= 1'b1;
			rx_cnt_q    <= '0;
			rx_shift_q  <= '0;
			held_q      <= '0;
			pending_q   <= 1'b0;
			read_mode_q <= 1'b0;
			answer_q    <= '0;
			tx_cnt_q    <= '0;
			drive_q     <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_n;
			last_scl_q  <= last_scl_n;
			last_sda_q  <= last_sda_n;
			rx_cnt_q    <= rx_cnt_n;
			rx_shift_q  <= rx_shift_n;
			held_q      <= held_n;
			pending_q   <= pending_n;
			read_mode_q <= read_mode_n;
			answer_q    <= answer_n;
			tx_cnt_q    <= tx_cnt_n;
			drive_q     <= drive_n;
		end
	end

	assign res.sda_pull       = drive_n;
	assign res.rx_byte        = held_n;
	assign res.rx_pending     = pending_n;
	assign res.bus_phase      = phase_code(phase_n);
	assign res.read_direction = read_mode_n;

endmodule

FILE: sv/i2cts_outbuf.sv
// Result register with a skid entry so the core can keep going for one result under output stall.
module i2cts_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cts_pkg::res_t   push_data,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_stall,
	output i2cts_pkg::res_t   out_data
);
	import i2cts_pkg::*;

	logic  out_valid_q;
	logic  skid_valid_q;
	res_t  out_data_q;
	res_t  skid_data_q;
	logic  pop;

	assign pop   = out_valid_q && !out_stall;
	assign ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_data_q <= skid_data_q;
		end else if (push) begin
			if (out_valid_q && !pop)
				skid_data_q <= push_data;
			else
				out_data_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/i2c_target_line_sampler_top.sv
// I2C target line sampler: input register, bus state machine, result buffer.
// A beat accepted into the input register goes through the state machine and is registered in the result buffer.
// One beat per cycle while in_stall is low; the state machine computes each next state combinationally.
// The skid entry in the result buffer lets input keep flowing for one stalled result.
// Reset (arst_n low, async): bus phase listen, SCL/SDA history high, counters,
// bytes and flags cleared, own_address set to 1, no beats held.
module i2c_target_line_sampler_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic       scl,
	input  logic       sda,
	input  logic [7:0] tx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       sda_pull,
	output logic [7:0] rx_byte,
	output logic       rx_pending,
	output logic [2:0] bus_phase,
	output logic       read_direction,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] own_address
);
	import i2cts_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic [6:0] own_addr_q;
	logic       buf_ready;
	logic       fire;
	logic       accept;
	res_t       core_res;
	res_t       out_res;

	assign fire      = valid_s1 && buf_ready;
	assign in_stall  = valid_s1 && !buf_ready;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			own_addr_q <= 7'd1;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (cfg_valid && cfg_ready)
				own_addr_q <= own_address;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command <= command;
			item_s1.scl     <= scl;
			item_s1.sda     <= sda;
			item_s1.tx_byte <= tx_byte;
		end
	end

	i2cts_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.own_address (own_addr_q),
		.res         (core_res)
	);

	i2cts_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (core_res),
		.ready     (buf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign sda_pull       = out_res.sda_pull;
	assign rx_byte        = out_res.rx_byte;
	assign rx_pending     = out_res.rx_pending;
	assign bus_phase      = out_res.bus_phase;
	assign read_direction = out_res.read_direction;

endmodule
